### hdl/scfc_pkg.sv
`timescale 1ns / 1ps

package scfc_pkg;

    // Register indexes on the configuration port
    typedef enum logic [0:0] {
        CFG_MAX_FRAME_LENGTH = 1'b0,
        CFG_MARKER_PATTERN   = 1'b1
    } cfg_index_t;

    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned MAX_LEN_BITS  = 17;

    localparam logic [MAX_LEN_BITS-1:0] MAX_FRAME_LENGTH_RESET = 17'h10000;
    localparam logic [31:0]             MARKER_PATTERN_RESET   = 32'hBAADF00D;

    // Status codes, first failing check wins in this order
    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_SHORT         = 4'd1,
        ST_BAD_TYPE      = 4'd2,
        ST_SIZE_MISMATCH = 4'd3,
        ST_OVERSIZE      = 4'd4,
        ST_ERROR_MSG     = 4'd5,
        ST_BAD_CHUNK     = 4'd6,
        ST_MARKER        = 4'd7,
        ST_BAD_CHANNEL   = 4'd8,
        ST_BAD_TOKEN     = 4'd9,
        ST_BAD_SEQUENCE  = 4'd10
    } status_t;

    // Header byte values
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_E = 8'h45;
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_H = 8'h48;
    localparam logic [7:0] CHR_M = 8'h4D;
    localparam logic [7:0] CHR_O = 8'h4F;
    localparam logic [7:0] CHR_R = 8'h52;

    localparam logic [31:0] ALL_ONES_WORD = 32'hFFFFFFFF;

    // Header field boundaries, as byte positions within the frame
    localparam int unsigned POS_CHUNK    = 3;
    localparam int unsigned POS_SIZE_END = 8;
    localparam int unsigned POS_CHAN_END = 12;
    localparam int unsigned POS_TOK_END  = 16;
    localparam int unsigned POS_SEQ_END  = 20;
    localparam int unsigned LEN_MIN      = 8;
    localparam int unsigned LEN_SEQ_OK   = 24;

    // Frame contents as they stand once the current byte is taken in
    typedef struct packed {
        logic [23:0] type_bytes;
        logic [7:0]  chunk_byte;
        logic [31:0] declared_length;
        logic [31:0] channel_word;
        logic [31:0] token_word;
        logic [31:0] sequence_word;
        logic        marker_seen;
    } frame_view_t;

endpackage

### hdl/scfc_byte_if.sv
`timescale 1ns / 1ps

interface scfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/scfc_result_if.sv
`timescale 1ns / 1ps

interface scfc_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] seq_value;
    logic        sequence_valid;

    modport source (output valid, output status, output seq_value,
                    output sequence_valid, input ready);
    modport sink (input valid, input status, input seq_value,
                  input sequence_valid, output ready);
endinterface

### hdl/scfc_frame_tracker.sv
`timescale 1ns / 1ps

module scfc_frame_tracker
    import scfc_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic [31:0]            marker_pattern,
    output frame_view_t            view,
    output logic [LENGTH_BITS-1:0] frame_len
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    frame_view_t            view_reg, view_next;
    logic [23:0]            window_reg, window_next;
    logic [31:0]            window;

    // Capture the header field that the current byte belongs to
    always_comb
    begin
        view_next = view_reg;
        window    = {window_reg, data_byte};

        if (count_reg < LENGTH_BITS'(POS_CHUNK))
        begin
            view_next.type_bytes = {view_reg.type_bytes[15:0], data_byte};
        end
        else if (count_reg == LENGTH_BITS'(POS_CHUNK))
        begin
            view_next.chunk_byte = data_byte;
        end
        else if (count_reg < LENGTH_BITS'(POS_SIZE_END))
        begin
            view_next.declared_length = {view_reg.declared_length[23:0], data_byte};
        end
        else if (count_reg < LENGTH_BITS'(POS_CHAN_END))
        begin
            view_next.channel_word = {view_reg.channel_word[23:0], data_byte};
        end
        else if (count_reg < LENGTH_BITS'(POS_TOK_END))
        begin
            view_next.token_word = {view_reg.token_word[23:0], data_byte};
        end
        else if (count_reg < LENGTH_BITS'(POS_SEQ_END))
        begin
            view_next.sequence_word = {view_reg.sequence_word[23:0], data_byte};
        end

        // Only four bytes that all belong to this frame are compared
        if ((count_reg >= LENGTH_BITS'(POS_CHUNK)) && (window == marker_pattern))
        begin
            view_next.marker_seen = 1'b1;
        end

        window_next = window[23:0];

        // The byte count sticks at its top value on very long frames
        if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign view      = view_next;
    assign frame_len = count_next;

    // Frame state, cleared after the final byte of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            view_reg   <= '0;
            window_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg  <= '0;
                view_reg   <= '0;
                window_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                view_reg   <= view_next;
                window_reg <= window_next;
            end
        end
    end

endmodule

### hdl/scfc_status_judge.sv
`timescale 1ns / 1ps

module scfc_status_judge
    import scfc_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 32
)
(
    input  frame_view_t             view,
    input  logic [LENGTH_BITS-1:0]  frame_len,
    input  logic [MAX_LEN_BITS-1:0] max_frame_length,
    output status_t                 status,
    output logic [31:0]             seq_value,
    output logic                    sequence_valid
);

    logic [31:0] len;
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [7:0]  t2;
    logic        type_ok;
    logic        chunk_ok;
    logic        channel_bad;
    logic        token_bad;

    assign len = 32'(frame_len);
    assign t0  = view.type_bytes[23:16];
    assign t1  = view.type_bytes[15:8];
    assign t2  = view.type_bytes[7:0];

    assign type_ok = (t0 == CHR_H) || (t0 == CHR_O) || (t0 == CHR_M) ||
                     (t0 == CHR_C) || (t0 == CHR_A) || (t0 == CHR_E);
    assign chunk_ok = (view.chunk_byte == CHR_F) || (view.chunk_byte == CHR_C) ||
                      (view.chunk_byte == CHR_A);
    assign channel_bad = (view.channel_word == '0) || (view.channel_word == ALL_ONES_WORD);
    assign token_bad   = (view.token_word == '0) || (view.token_word == ALL_ONES_WORD);

    // Checks in priority order; the first one that fails sets the status
    always_comb
    begin
        if (len < 32'(LEN_MIN))
        begin
            status = ST_SHORT;
        end
        else if (!type_ok)
        begin
            status = ST_BAD_TYPE;
        end
        else if ((view.declared_length != '0) && (view.declared_length != len))
        begin
            status = ST_SIZE_MISMATCH;
        end
        else if (len > 32'(max_frame_length))
        begin
            status = ST_OVERSIZE;
        end
        else if ((t0 == CHR_E) && (t1 == CHR_R) && (t2 == CHR_R))
        begin
            status = ST_ERROR_MSG;
        end
        else if (!chunk_ok)
        begin
            status = ST_BAD_CHUNK;
        end
        else if (view.marker_seen)
        begin
            status = ST_MARKER;
        end
        else if ((len >= 32'(POS_TOK_END)) && channel_bad)
        begin
            status = ST_BAD_CHANNEL;
        end
        else if ((len >= 32'(POS_SEQ_END)) && token_bad)
        begin
            status = ST_BAD_TOKEN;
        end
        else if ((len >= 32'(LEN_SEQ_OK)) && (view.sequence_word == ALL_ONES_WORD))
        begin
            status = ST_BAD_SEQUENCE;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // The sequence number is reported only for a clean frame that carried it
    assign sequence_valid = (status == ST_OK) && (len >= 32'(LEN_SEQ_OK));
    assign seq_value      = sequence_valid ? view.sequence_word : '0;

endmodule

### hdl/secure_channel_frame_checker_core.sv
`timescale 1ns / 1ps

// Channel    | Direction | Payload                            | Transfers
// frame_bytes| in        | data_byte, last_byte               | one per frame byte
// results    | out       | status, seq_value, sequence_valid  | one per frame, on last byte
//
// One byte is taken per cycle unless a final byte is held back by a waiting result.
// A byte is held in the input register; the capture, marker compare and status checks
// then run in one pass into the result register, which presents each frame's result.
// Reset clears the frame state and loads the register defaults; no clearing pass.
// A waiting result stalls only final bytes: other bytes keep flowing while the
// result register is full.

module secure_channel_frame_checker_core
    import scfc_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    scfc_byte_if.sink                frame_bytes,
    scfc_result_if.source            results
);

    logic [MAX_LEN_BITS-1:0] max_len_reg;
    logic [31:0]             marker_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    frame_view_t            view;
    logic [LENGTH_BITS-1:0] frame_len;
    status_t                status;
    logic [31:0]            seq_number;
    logic                   seq_valid;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_seq_reg;
    logic        out_seqv_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_FRAME_LENGTH_RESET;
            marker_reg  <= MARKER_PATTERN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_FRAME_LENGTH: max_len_reg <= cfg_wdata[MAX_LEN_BITS-1:0];
                CFG_MARKER_PATTERN:   marker_reg  <= cfg_wdata[31:0];
                default:              ;
            endcase
        end
    end

    // The held byte moves on unless it ends a frame and the result register is blocked
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || results.ready);
    assign frame_bytes.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_bytes.ready)
        begin
            in_valid_reg <= frame_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_bytes.valid && frame_bytes.ready)
        begin
            in_byte_reg <= frame_bytes.data_byte;
            in_last_reg <= frame_bytes.last_byte;
        end
    end

    scfc_frame_tracker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .last_byte      (in_last_reg),
        .marker_pattern (marker_reg),
        .view           (view),
        .frame_len      (frame_len)
    );

    scfc_status_judge #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_judge (
        .view             (view),
        .frame_len        (frame_len),
        .max_frame_length (max_len_reg),
        .status           (status),
        .seq_value        (seq_number),
        .sequence_valid   (seq_valid)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_status_reg <= status;
            out_seq_reg    <= seq_number;
            out_seqv_reg   <= seq_valid;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.status         = out_status_reg;
    assign results.seq_value      = out_seq_reg;
    assign results.sequence_valid = out_seqv_reg;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scfc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned RANDOM_BUDGET = 160;

    typedef logic [7:0] byte_q_t[$];

    // Faults injected into otherwise well-formed frames
    typedef enum int {
        FAULT_BAD_TYPE,
        FAULT_SIZE,
        FAULT_ERR_MSG,
        FAULT_BAD_CHUNK,
        FAULT_MARKER,
        FAULT_MARKER_AT_END,
        FAULT_CHANNEL,
        FAULT_TOKEN,
        FAULT_SEQUENCE,
        FAULT_SHORT
    } frame_fault_t;

    // Frame checker scoreboard: tracks the frame in progress and queues verdicts.
    class frame_scoreboard;
        typedef struct {
            status_t     status;
            logic [31:0] seq_value;
            logic        sequence_valid;
        } verdict_t;

        logic [MAX_LEN_BITS-1:0] max_len;
        logic [31:0]             marker;

        logic [31:0] byte_count;
        logic [23:0] type_bytes;
        logic [7:0]  chunk_byte;
        logic [31:0] declared_len;
        logic [31:0] channel_word;
        logic [31:0] token_word;
        logic [31:0] sequence_word;
        logic [23:0] recent_bytes;
        logic        marker_seen;

        verdict_t verdicts[$];
        int       errors;

        function new();
            max_len = MAX_FRAME_LENGTH_RESET;
            marker  = MARKER_PATTERN_RESET;
            errors  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count    = '0;
            type_bytes    = '0;
            chunk_byte    = '0;
            declared_len  = '0;
            channel_word  = '0;
            token_word    = '0;
            sequence_word = '0;
            recent_bytes  = '0;
            marker_seen   = 1'b0;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // First failing check wins.
        function status_t judge_frame();
            logic [7:0] t0;
            t0 = type_bytes[23:16];
            if (byte_count < LEN_MIN)
                return ST_SHORT;
            if (!(t0 inside {CHR_H, CHR_O, CHR_M, CHR_C, CHR_A, CHR_E}))
                return ST_BAD_TYPE;
            if (declared_len != 0 && declared_len != byte_count)
                return ST_SIZE_MISMATCH;
            if (byte_count > max_len)
                return ST_OVERSIZE;
            if (type_bytes == {CHR_E, CHR_R, CHR_R})
                return ST_ERROR_MSG;
            if (!(chunk_byte inside {CHR_F, CHR_C, CHR_A}))
                return ST_BAD_CHUNK;
            if (marker_seen)
                return ST_MARKER;
            if (byte_count >= 16 && (channel_word == 0 || channel_word == ALL_ONES_WORD))
                return ST_BAD_CHANNEL;
            if (byte_count >= 20 && (token_word == 0 || token_word == ALL_ONES_WORD))
                return ST_BAD_TOKEN;
            if (byte_count >= LEN_SEQ_OK && sequence_word == ALL_ONES_WORD)
                return ST_BAD_SEQUENCE;
            return ST_OK;
        endfunction

        // Takes in one accepted frame byte; the final byte queues a verdict.
        function void note_byte(logic [7:0] b, logic last);
            logic [31:0] pos;
            logic [31:0] window;
            verdict_t    v;
            pos    = byte_count;
            window = {recent_bytes, b};
            if (pos < POS_CHUNK)
                type_bytes = {type_bytes[15:0], b};
            else if (pos == POS_CHUNK)
                chunk_byte = b;
            else if (pos < POS_SIZE_END)
                declared_len = {declared_len[23:0], b};
            else if (pos < POS_CHAN_END)
                channel_word = {channel_word[23:0], b};
            else if (pos < POS_TOK_END)
                token_word = {token_word[23:0], b};
            else if (pos < POS_SEQ_END)
                sequence_word = {sequence_word[23:0], b};
            if (pos >= POS_CHUNK && window == marker)
                marker_seen = 1'b1;
            recent_bytes = window[23:0];
            if (byte_count != ALL_ONES_WORD)
                byte_count = byte_count + 1;
            if (last)
            begin
                v.status = judge_frame();
                if (v.status == ST_OK && byte_count >= LEN_SEQ_OK)
                begin
                    v.seq_value      = sequence_word;
                    v.sequence_valid = 1'b1;
                end
                else
                begin
                    v.seq_value      = '0;
                    v.sequence_valid = 1'b0;
                end
                verdicts.push_back(v);
                clear_frame();
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [3:0] status, logic [31:0] seq_num, logic seq_valid);
            verdict_t v;
            if (verdicts.size() == 0)
            begin
                report("result with none pending", status, 0);
                return;
            end
            v = verdicts.pop_front();
            if (status !== v.status)
                report("status", status, v.status);
            if (seq_num !== v.seq_value)
                report("seq_value", seq_num, v.seq_value);
            if (seq_valid !== v.sequence_valid)
                report("sequence_valid", seq_valid, v.sequence_valid);
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [0:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     steady;
    logic [31:0]              cur_marker;
    int unsigned              quiet_cycles;

    logic [7:0] type_chars[6]  = '{CHR_H, CHR_O, CHR_M, CHR_C, CHR_A, CHR_E};
    logic [7:0] chunk_chars[3] = '{CHR_F, CHR_C, CHR_A};

    frame_scoreboard sb;

    scfc_byte_if   frame_bytes_if ();
    scfc_result_if results_if ();

    secure_channel_frame_checker_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .frame_bytes (frame_bytes_if),
        .results     (results_if)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Writes a big-endian word at a byte position, as far as the frame reaches.
    function automatic void set_word(ref byte_q_t q, input int at, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            if (at + i < q.size())
                q[at + i] = w[31 - 8*i -: 8];
        end
    endfunction

    function automatic logic [31:0] good_id();
        logic [31:0] w;
        do
            w = $urandom;
        while (w == 0 || w == ALL_ONES_WORD);
        return w;
    endfunction

    // Well-formed frame of the given length with random content.
    function automatic void make_frame(input int len, ref byte_q_t q);
        int full;
        full = (len > LEN_SEQ_OK) ? len : LEN_SEQ_OK;
        q = {};
        repeat (full)
            q.push_back(8'($urandom));
        q[0] = type_chars[$urandom_range(0, 5)];
        q[POS_CHUNK] = chunk_chars[$urandom_range(0, 2)];
        set_word(q, 4, $urandom_range(0, 1) ? 32'(len) : 32'd0);
        set_word(q, POS_SIZE_END, good_id());
        set_word(q, POS_CHAN_END, good_id());
        set_word(q, POS_TOK_END, good_id() >> $urandom_range(0, 1));
        while (q.size() > len)
            void'(q.pop_back());
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(1, 7);
        if (r < 80)
            return $urandom_range(8, 40);
        return $urandom_range(41, 100);
    endfunction

    // Breaks one rule of an otherwise well-formed frame.
    function automatic void inject_fault(ref byte_q_t q);
        frame_fault_t fault;
        logic [7:0]   b;
        int           n;
        fault = frame_fault_t'($urandom_range(0, 9));
        n = q.size();
        case (fault)
            FAULT_BAD_TYPE:
            begin
                do
                    b = 8'($urandom);
                while (b inside {CHR_H, CHR_O, CHR_M, CHR_C, CHR_A, CHR_E});
                q[0] = b;
            end
            FAULT_SIZE:
                set_word(q, 4, 32'(n + $urandom_range(1, 1000)));
            FAULT_ERR_MSG:
            begin
                q[0] = CHR_E;
                if (n > 1)
                    q[1] = CHR_R;
                if (n > 2)
                    q[2] = CHR_R;
            end
            FAULT_BAD_CHUNK:
            begin
                do
                    b = 8'($urandom);
                while (b inside {CHR_F, CHR_C, CHR_A});
                if (n > POS_CHUNK)
                    q[POS_CHUNK] = b;
            end
            FAULT_MARKER:
            begin
                if (n >= 4)
                    set_word(q, $urandom_range(0, n - 4), cur_marker);
            end
            FAULT_MARKER_AT_END:
            begin
                if (n >= 4)
                    set_word(q, n - 4, cur_marker);
            end
            FAULT_CHANNEL:
                set_word(q, POS_SIZE_END, $urandom_range(0, 1) ? ALL_ONES_WORD : 32'd0);
            FAULT_TOKEN:
                set_word(q, POS_CHAN_END, $urandom_range(0, 1) ? ALL_ONES_WORD : 32'd0);
            FAULT_SEQUENCE:
                set_word(q, POS_TOK_END, ALL_ONES_WORD);
            FAULT_SHORT:
            begin
                while (q.size() > 1 && q.size() > $urandom_range(1, 7))
                    void'(q.pop_back());
            end
            default:
                q[0] = q[0];
        endcase
    endfunction

    // One byte transfer; valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            frame_bytes_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_bytes_if.valid     = 1'b1;
        frame_bytes_if.data_byte = d;
        frame_bytes_if.last_byte = last;
        @(posedge clk);
        while (!frame_bytes_if.ready)
            @(posedge clk);
    endtask

    task automatic send_frame(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    // Stops sending and waits until every verdict has been matched.
    task automatic drain();
        @(negedge clk);
        frame_bytes_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_MAX_FRAME_LENGTH)
            sb.max_len = value[MAX_LEN_BITS-1:0];
        else
        begin
            sb.marker  = value;
            cur_marker = value;
        end
    endtask

    task automatic random_frames(input int budget);
        byte_q_t q;
        int      sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 5) == 0)
                steady = ~steady;
            make_frame(pick_len(), q);
            if ($urandom_range(0, 99) < 45)
                inject_fault(q);
            send_frame(q);
            sent += q.size();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        steady = 1'b0;
    endtask

    // Result sink with random stalls.
    initial
    begin
        int gap;
        results_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                results_if.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            results_if.ready = 1'b1;
        end
    end

    // Monitors on both channels.
    always @(posedge clk)
    begin
        if (rst_n && frame_bytes_if.valid && frame_bytes_if.ready)
            sb.note_byte(frame_bytes_if.data_byte, frame_bytes_if.last_byte);
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_result(results_if.status, results_if.seq_value,
                            results_if.sequence_valid);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((frame_bytes_if.valid && frame_bytes_if.ready) ||
            (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        byte_q_t q;
        sb                       = new();
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_MAX_FRAME_LENGTH;
        cfg_wdata                = '0;
        frame_bytes_if.valid     = 1'b0;
        frame_bytes_if.data_byte = '0;
        frame_bytes_if.last_byte = 1'b0;
        steady                   = 1'b0;
        cur_marker               = MARKER_PATTERN_RESET;
        quiet_cycles             = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed frames under the reset register values.
        make_frame(1, q);
        send_frame(q);
        make_frame(7, q);
        send_frame(q);
        make_frame(8, q);
        set_word(q, 4, 32'd0);
        send_frame(q);
        make_frame(24, q);
        set_word(q, 4, 32'd24);
        send_frame(q);
        make_frame(8, q);
        q[0] = 8'hFF;
        send_frame(q);
        make_frame(8, q);
        q[0] = 8'h00;
        send_frame(q);
        make_frame(12, q);
        set_word(q, 4, 32'd13);
        send_frame(q);
        make_frame(8, q);
        q[0] = CHR_E;
        q[1] = CHR_R;
        q[2] = CHR_R;
        send_frame(q);
        make_frame(8, q);
        q[POS_CHUNK] = 8'h00;
        send_frame(q);
        make_frame(30, q);
        set_word(q, 20, cur_marker);
        send_frame(q);
        make_frame(28, q);
        set_word(q, 24, cur_marker);
        send_frame(q);

        // Identifier checks just below and at their length thresholds.
        make_frame(15, q);
        set_word(q, POS_SIZE_END, 32'd0);
        send_frame(q);
        make_frame(16, q);
        set_word(q, POS_SIZE_END, 32'd0);
        send_frame(q);
        make_frame(16, q);
        set_word(q, POS_SIZE_END, ALL_ONES_WORD);
        send_frame(q);
        make_frame(19, q);
        set_word(q, POS_CHAN_END, ALL_ONES_WORD);
        send_frame(q);
        make_frame(20, q);
        set_word(q, POS_CHAN_END, 32'd0);
        send_frame(q);
        make_frame(23, q);
        set_word(q, POS_TOK_END, ALL_ONES_WORD);
        send_frame(q);
        make_frame(24, q);
        set_word(q, POS_TOK_END, ALL_ONES_WORD);
        send_frame(q);
        drain();

        // Marker in the header, and a marker that would straddle two frames.
        write_reg(CFG_MARKER_PATTERN, {CHR_H, CHR_O, CHR_M, CHR_F});
        make_frame(8, q);
        q[0] = CHR_H;
        q[1] = CHR_O;
        q[2] = CHR_M;
        q[POS_CHUNK] = CHR_F;
        send_frame(q);
        drain();
        write_reg(CFG_MARKER_PATTERN, {8'h11, CHR_H, CHR_O, CHR_M});
        make_frame(10, q);
        q[9] = 8'h11;
        send_frame(q);
        make_frame(8, q);
        q[0] = CHR_H;
        q[1] = CHR_O;
        q[2] = CHR_M;
        send_frame(q);
        random_frames(RANDOM_BUDGET / 2);
        drain();

        // Smallest length limit.
        write_reg(CFG_MAX_FRAME_LENGTH, 32'd8);
        write_reg(CFG_MARKER_PATTERN, $urandom);
        random_frames(RANDOM_BUDGET / 2);
        drain();

        // Largest length limit with an all-zero marker.
        write_reg(CFG_MAX_FRAME_LENGTH, 32'h10000);
        write_reg(CFG_MARKER_PATTERN, 32'd0);
        random_frames(RANDOM_BUDGET);
        drain();

        write_reg(CFG_MAX_FRAME_LENGTH, $urandom_range(8, 120));
        write_reg(CFG_MARKER_PATTERN, ALL_ONES_WORD);
        random_frames(RANDOM_BUDGET);
        drain();

        write_reg(CFG_MAX_FRAME_LENGTH, $urandom_range(16, 100));
        write_reg(CFG_MARKER_PATTERN, $urandom);
        random_frames(RANDOM_BUDGET);
        drain();

        // Frames at and just over a length limit, then back to the reset values.
        write_reg(CFG_MAX_FRAME_LENGTH, 32'd40);
        write_reg(CFG_MARKER_PATTERN, 32'hBAADF00D);
        steady = 1'b1;
        make_frame(40, q);
        set_word(q, 4, 32'd40);
        send_frame(q);
        make_frame(41, q);
        set_word(q, 4, 32'd0);
        send_frame(q);
        steady = 1'b0;
        drain();
        write_reg(CFG_MAX_FRAME_LENGTH, 32'h10000);
        random_frames(RANDOM_BUDGET);
        drain();

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
